// File: hw/rtl/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int PROBE_W = 4;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    // One search result
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [PROBE_W-1:0] probe_count;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sts_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sts_cmd_if
    import sts_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink (input valid, input command, input item_value, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/sts_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sts_res_if
    import sts_pkg::*;
();

    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [PROBE_W-1:0] probe_count;

    modport source (output valid, output found, output match_index, output probe_count,
                    input ready);
    modport sink (input valid, input found, input match_index, input probe_count,
                  output ready);

endinterface

`default_nettype wire

// File: hw/rtl/sts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/sts_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Command sequencer: table loading and the probe loop of a search
module sts_engine
    import sts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    sts_cmd_if.sink                cmd,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [DATA_W-1:0]      ram_wdata,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [DATA_W-1:0] ram_rdata,
    output logic                   res_valid,
    input  wire logic              res_take,
    output result_t                result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   lo_reg, lo_next;
    logic [COUNT_W-1:0]   hi_reg, hi_next;     // exclusive upper bound
    logic [COUNT_W-1:0]   mid_reg, mid_next;
    logic [PROBE_W-1:0]   probe_reg, probe_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    result_t              result_reg, result_next;

    logic signed [DATA_W-1:0] entry;
    logic [PROBE_W-1:0]   probe_inc;
    logic [PROBE_W-1:0]   probe_miss;
    logic [COUNT_W:0]     mid_sum;

    // Saturating probe counters
    assign entry      = $signed(ram_rdata);
    assign probe_inc  = (probe_reg == PROBE_MAX) ? probe_reg : probe_reg + PROBE_W'(1);
    assign probe_miss = (probe_inc == PROBE_MAX) ? probe_inc : probe_inc + PROBE_W'(1);

    // Next state, bounds and memory access
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        probe_next  = probe_reg;
        key_next    = key_reg;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[ADDR_W-1:0];
        ram_wdata   = cmd.item_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < COUNT_W'(TABLE_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        CMD_SEARCH:
                        begin
                            key_next   = cmd.item_value;
                            lo_next    = '0;
                            hi_next    = count_reg;
                            probe_next = '0;
                            if (count_reg == '0)
                            begin
                                // empty table: one step, miss
                                result_next.found       = 1'b0;
                                result_next.match_index = '0;
                                result_next.probe_count = PROBE_W'(1);
                                state_next              = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_PROBE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                probe_next = probe_inc;
                if (entry == key_reg)
                begin
                    result_next.found       = 1'b1;
                    result_next.match_index = INDEX_W'(mid_reg);
                    result_next.probe_count = probe_inc;
                    state_next              = ST_FINISH;
                end
                else
                begin
                    if (entry > key_reg)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + COUNT_W'(1);
                    end
                    // bounds crossed: miss with one extra step
                    if (lo_next >= hi_next)
                    begin
                        result_next.found       = 1'b0;
                        result_next.match_index = '0;
                        result_next.probe_count = probe_miss;
                        state_next              = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Midpoint of the next bounds, issued to the memory at once
        mid_sum   = {1'b0, lo_next} + {1'b0, hi_next} - (COUNT_W + 1)'(1);
        mid_next  = mid_sum[COUNT_W:1];
        ram_raddr = mid_next[ADDR_W-1:0];
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        probe_reg  <= probe_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_table_binary_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear and append transactions leave the engine idle, so a new command is taken the next cycle.
// A search runs the probe state once per memory probe (one synchronous read per cycle, at most 11
// for a 1024-entry table), then the finish state, then the output register holding the result.
// Searches are handled one at a time: a new command is taken only after the finish state.
// Reset clears the entry count and the control state; the table RAM is not cleared.

module sorted_table_binary_search_core
    import sts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sts_cmd_if.sink   cmd,
    sts_res_if.source res
);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              eng_valid;
    logic              eng_take;
    result_t           eng_result;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    // Table storage
    sts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command sequencer
    sts_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (eng_valid),
        .res_take  (eng_take),
        .result    (eng_result)
    );

    // Output register, decouples the sequencer from result back-pressure
    assign eng_take = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_valid && eng_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && eng_take)
        begin
            out_data_reg <= eng_result;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.found       = out_data_reg.found;
    assign res.match_index = out_data_reg.match_index;
    assign res.probe_count = out_data_reg.probe_count;

endmodule

`default_nettype wire
